// ===== rtl/i2cms_pkg.sv =====
// Shared types and codes for the I2C master transaction sequencer.
package i2cms_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Transaction kinds.
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_READ8   = 2'd2;
  localparam logic [1:0] KIND_READ16  = 2'd3;

  // Sequencer modes.
  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;
  localparam logic [1:0] MODE_OFFREAD = 2'd3;

  // Recorded outcome of the last transaction.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_ADDR  = 2'd1;
  localparam logic [1:0] ERR_DATA  = 2'd2;
  localparam logic [1:0] ERR_OTHER = 2'd3;

  // Bus actions.
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_NACK    = 3'd3;
  localparam logic [2:0] ACT_START   = 3'd4;
  localparam logic [2:0] ACT_RSTART  = 3'd5;
  localparam logic [2:0] ACT_STOP    = 3'd6;
  localparam logic [2:0] ACT_RELEASE = 3'd7;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_BAD_ARGS  = 3'd2;
  localparam logic [2:0] ST_ADDR_NACK = 3'd3;
  localparam logic [2:0] ST_DATA_NACK = 3'd4;
  localparam logic [2:0] ST_OTHER     = 3'd5;

  // Bus engine status codes, low three bits masked off.
  localparam logic [7:0] BS_BUS_ERROR    = 8'h00;
  localparam logic [7:0] BS_START        = 8'h08;
  localparam logic [7:0] BS_RSTART       = 8'h10;
  localparam logic [7:0] BS_MT_ADDR_ACK  = 8'h18;
  localparam logic [7:0] BS_MT_ADDR_NACK = 8'h20;
  localparam logic [7:0] BS_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] BS_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] BS_ARB_LOST     = 8'h38;
  localparam logic [7:0] BS_MR_ADDR_ACK  = 8'h40;
  localparam logic [7:0] BS_MR_ADDR_NACK = 8'h48;
  localparam logic [7:0] BS_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] BS_MR_DATA_NACK = 8'h58;

  localparam logic [5:0] IDX_MAX = 6'h3F;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  kind;
    logic [6:0]  device_address;
    logic [15:0] reg_offset;
    logic [5:0]  xfer_length;
    logic [4:0]  buf_slot;
    logic [7:0]  data_byte;
    logic [7:0]  bus_status;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [5:0] rx_count;
    logic [2:0] result_status;
  } out_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] error_kind;
    logic [7:0] addr_rw_byte;
    logic [7:0] offset_high;
    logic [7:0] offset_low;
    logic [1:0] offset_left;
    logic [5:0] byte_index;
    logic [5:0] byte_limit;
  } seq_state_t;

endpackage

// ===== rtl/i2cms_ram.sv =====
// Generic single-port-write RAM with a registered read.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/i2cms_step.sv =====
// Decision logic for one item: next sequencer state, result item and store write.
module i2cms_step import i2cms_pkg::*; #(
  parameter int BUF_DEPTH = 32
) (
  input  seq_state_t cur,
  input  in_item_t   item,
  input  logic [7:0] store_byte,
  output seq_state_t nxt,
  output out_item_t  res,
  output logic       store_we
);

  localparam logic [8:0] DEPTH_V = 9'(BUF_DEPTH);

  logic [7:0] code;
  logic       status_set;
  logic [2:0] status;
  logic       slot_ok;
  logic       len_bad;
  logic       send_ok;

  function automatic logic [5:0] bump(input logic [5:0] idx);
    return (idx == IDX_MAX) ? idx : idx + 6'd1;
  endfunction

  assign code    = {item.bus_status[7:3], 3'b000};
  assign slot_ok = {4'b0, item.buf_slot} < DEPTH_V;
  assign len_bad = ({3'b0, item.xfer_length} > DEPTH_V) ||
                   ((item.kind != KIND_WRITE) && (item.xfer_length == 6'd0));
  assign send_ok = (cur.byte_index < cur.byte_limit) &&
                   ({3'b0, cur.byte_index} < DEPTH_V);

  always_comb begin
    nxt        = cur;
    res        = '0;
    status_set = 1'b0;
    status     = ST_OK;
    store_we   = 1'b0;

    unique case (item.opcode)
      OP_LOAD: begin
        store_we = (cur.mode == MODE_READY) && slot_ok;
      end
      OP_BEGIN: begin
        status_set = 1'b1;
        if (len_bad) begin
          status = ST_BAD_ARGS;
        end else if (cur.mode != MODE_READY) begin
          status = ST_BUSY;
        end else begin
          status           = ST_OK;
          res.bus_action   = ACT_START;
          nxt.error_kind   = ERR_NONE;
          nxt.byte_index   = 6'd0;
          nxt.byte_limit   = item.xfer_length;
          nxt.addr_rw_byte = {item.device_address, item.kind == KIND_READ};
          unique case (item.kind)
            KIND_WRITE: nxt.mode = MODE_WRITE;
            KIND_READ:  nxt.mode = MODE_READ;
            KIND_READ8: begin
              nxt.mode        = MODE_OFFREAD;
              nxt.offset_low  = item.reg_offset[7:0];
              nxt.offset_left = 2'd1;
            end
            default: begin
              nxt.mode        = MODE_OFFREAD;
              nxt.offset_low  = item.reg_offset[7:0];
              nxt.offset_high = item.reg_offset[15:8];
              nxt.offset_left = 2'd2;
            end
          endcase
        end
      end
      OP_EVENT: begin
        if (cur.mode != MODE_READY) begin
          unique case (code)
            BS_START, BS_RSTART: begin
              res.bus_action = ACT_SEND;
              res.tx_byte    = cur.addr_rw_byte;
            end
            BS_MT_ADDR_ACK, BS_MT_DATA_ACK: begin
              if (cur.mode == MODE_OFFREAD) begin
                // Offset bytes go out high first; a data ack after the last one
                // turns the bus around with a repeated start.
                if (code == BS_MT_ADDR_ACK) begin
                  res.bus_action = ACT_SEND;
                  if (cur.offset_left == 2'd2) begin
                    res.tx_byte     = cur.offset_high;
                    nxt.offset_left = 2'd1;
                  end else begin
                    res.tx_byte     = cur.offset_low;
                    nxt.offset_left = 2'd0;
                  end
                end else if (cur.offset_left == 2'd1) begin
                  res.bus_action  = ACT_SEND;
                  res.tx_byte     = cur.offset_low;
                  nxt.offset_left = 2'd0;
                end else begin
                  nxt.addr_rw_byte[0] = 1'b1;
                  nxt.offset_left     = 2'd0;
                  res.bus_action      = ACT_RSTART;
                end
              end else if (send_ok) begin
                res.bus_action = ACT_SEND;
                res.tx_byte    = store_byte;
                nxt.byte_index = bump(cur.byte_index);
              end else begin
                res.bus_action = ACT_STOP;
                nxt.mode       = MODE_READY;
                nxt.error_kind = ERR_NONE;
              end
            end
            BS_MT_ADDR_NACK, BS_MR_ADDR_NACK: begin
              res.bus_action = ACT_STOP;
              nxt.mode       = MODE_READY;
              nxt.error_kind = ERR_ADDR;
            end
            BS_MT_DATA_NACK: begin
              res.bus_action = ACT_STOP;
              nxt.mode       = MODE_READY;
              nxt.error_kind = ERR_DATA;
            end
            BS_ARB_LOST: begin
              res.bus_action = ACT_RELEASE;
              nxt.mode       = MODE_READY;
              nxt.error_kind = ERR_OTHER;
            end
            BS_MR_ADDR_ACK, BS_MR_DATA_ACK: begin
              if (code == BS_MR_DATA_ACK) begin
                res.rx_valid   = 1'b1;
                res.rx_byte    = item.data_byte;
                nxt.byte_index = bump(cur.byte_index);
              end
              // Ack while another byte is still wanted after the next one.
              res.bus_action = (({1'b0, nxt.byte_index} + 7'd1) < {1'b0, cur.byte_limit}) ?
                               ACT_ACK : ACT_NACK;
            end
            BS_MR_DATA_NACK: begin
              res.rx_valid   = 1'b1;
              res.rx_byte    = item.data_byte;
              nxt.byte_index = bump(cur.byte_index);
              res.bus_action = ACT_STOP;
              nxt.mode       = MODE_READY;
              nxt.error_kind = ERR_NONE;
            end
            BS_BUS_ERROR: begin
              res.bus_action = ACT_STOP;
              nxt.mode       = MODE_READY;
              nxt.error_kind = ERR_OTHER;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    if (!status_set) begin
      if (nxt.mode != MODE_READY) begin
        status = ST_BUSY;
      end else begin
        unique case (nxt.error_kind)
          ERR_NONE: status = ST_OK;
          ERR_ADDR: status = ST_ADDR_NACK;
          ERR_DATA: status = ST_DATA_NACK;
          default:  status = ST_OTHER;
        endcase
      end
    end
    res.rx_count      = nxt.byte_index;
    res.result_status = status;
  end

endmodule

// ===== rtl/i2c_master_transaction_sequencer.sv =====
// Top level of the I2C master transaction sequencer.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | in_data  (in_item_t)
//   out     | output    | out_valid/out_stall| out_data (out_item_t)
//
// One item is taken per cycle while in_stall is low; it passes the input register, then
// the result register, whose output is out_data; a held out_stall can keep it in between.
// A single decision stage lies between the two registers.
// The write byte store is a RAM with a registered read, addressed ahead at the next byte index.
// Reset clears the sequencer state and empties both pipeline registers; the store is not cleared.
// A held out_stall keeps the result; the input register then fills and in_stall rises.
module i2c_master_transaction_sequencer import i2cms_pkg::*; #(
  parameter int BUF_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic       in_full;
  in_item_t   in_q;
  logic       out_full;
  out_item_t  out_q;
  seq_state_t state;
  seq_state_t state_next;
  out_item_t  step_res;
  logic       step_we;
  logic       proc;
  logic [7:0] store_byte;
  logic [5:0] read_index;

  assign proc      = in_full && (!out_full || !out_stall);
  assign in_stall  = in_full && !proc;
  assign out_valid = out_full;
  assign out_data  = out_q;

  // The store is always read at the index the next item will see.
  assign read_index = proc ? state_next.byte_index : state.byte_index;

  i2cms_step #(.BUF_DEPTH(BUF_DEPTH)) u_step (
    .cur        (state),
    .item       (in_q),
    .store_byte (store_byte),
    .nxt        (state_next),
    .res        (step_res),
    .store_we   (step_we)
  );

  i2cms_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_store (
    .clk   (clk),
    .we    (proc && step_we),
    .waddr (ADDR_W'(in_q.buf_slot)),
    .wdata (in_q.data_byte),
    .raddr (ADDR_W'(read_index)),
    .rdata (store_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
      state    <= '0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (proc) begin
        state    <= state_next;
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (proc) begin
      out_q <= step_res;
    end
  end

endmodule

// ===== rtl/i2cms_checker.sv =====
// Port-level checks for the I2C master transaction sequencer.
module i2cms_checker import i2cms_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled input item stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.bus_action != ACT_SEND) |-> out_data.tx_byte == 8'd0)
    else $error("tx byte set without a send");

  a_rx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rx_valid |->
      (out_data.bus_action == ACT_ACK || out_data.bus_action == ACT_NACK ||
       out_data.bus_action == ACT_STOP))
    else $error("received byte with an unexpected bus action");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the I2C master transaction sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cms_pkg::*;

  localparam int BUF_DEPTH = 32;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  // Sequencer state as the checker and the stimulus planner track it.
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] err;
    logic [7:0] addr_rw;
    logic [7:0] off_hi;
    logic [7:0] off_lo;
    logic [1:0] off_left;
    logic [5:0] idx;
    logic [5:0] limit;
  } seq_model_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  i2c_master_transaction_sequencer #(.BUF_DEPTH(BUF_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Planner side: state seen by the stimulus, and which store slots hold data.
  seq_model_t plan_st = '0;
  logic       slot_loaded [BUF_DEPTH];
  logic [2:0] last_act = ACT_NONE;
  logic       addr_phase = 1'b0;
  logic       hold_next = 1'b0;
  int         live_items = 0;

  // Checker side.
  seq_model_t chk_st = '0;
  logic [7:0] chk_store [BUF_DEPTH];

  in_item_t   tx_items [$];
  logic       tx_hold [$];
  out_item_t  predicted_results [$];
  int         tx_total = 0;
  int         accepted_items = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  logic       tx_quiet = 1'b0;
  logic       rx_quiet = 1'b0;

  // One step of the sequencer. store_byte is the store entry at the current byte index;
  // load_ok tells the caller to write the loaded byte into its store.
  function automatic out_item_t sequence_step(inout seq_model_t st, input in_item_t it,
                                              input logic [7:0] store_byte,
                                              output logic load_ok);
    out_item_t  r;
    logic [7:0] code;
    logic       status_set;
    r = '0;
    load_ok = 1'b0;
    status_set = 1'b0;
    code = {it.bus_status[7:3], 3'b000};
    case (it.opcode)
      OP_LOAD: load_ok = (st.mode == MODE_READY);
      OP_BEGIN: begin
        status_set = 1'b1;
        if (it.xfer_length > BUF_DEPTH || (it.kind != KIND_WRITE && it.xfer_length == 6'd0)) begin
          r.result_status = ST_BAD_ARGS;
        end else if (st.mode != MODE_READY) begin
          r.result_status = ST_BUSY;
        end else begin
          r.result_status = ST_OK;
          r.bus_action = ACT_START;
          st.err = ERR_NONE;
          st.idx = 6'd0;
          st.limit = it.xfer_length;
          st.addr_rw = {it.device_address, it.kind == KIND_READ};
          case (it.kind)
            KIND_WRITE: st.mode = MODE_WRITE;
            KIND_READ: st.mode = MODE_READ;
            default: begin
              st.mode = MODE_OFFREAD;
              st.off_lo = it.reg_offset[7:0];
              if (it.kind == KIND_READ16) begin
                st.off_hi = it.reg_offset[15:8];
                st.off_left = 2'd2;
              end else begin
                st.off_left = 2'd1;
              end
            end
          endcase
        end
      end
      OP_EVENT: begin
        if (st.mode != MODE_READY) begin
          case (code)
            BS_START, BS_RSTART: begin
              r.bus_action = ACT_SEND;
              r.tx_byte = st.addr_rw;
            end
            BS_MT_ADDR_ACK, BS_MT_DATA_ACK: begin
              if (st.mode == MODE_OFFREAD) begin
                if (code == BS_MT_ADDR_ACK) begin
                  r.bus_action = ACT_SEND;
                  if (st.off_left == 2'd2) begin
                    r.tx_byte = st.off_hi;
                    st.off_left = 2'd1;
                  end else begin
                    r.tx_byte = st.off_lo;
                    st.off_left = 2'd0;
                  end
                end else if (st.off_left == 2'd1) begin
                  r.bus_action = ACT_SEND;
                  r.tx_byte = st.off_lo;
                  st.off_left = 2'd0;
                end else begin
                  // Offset is out: turn the bus around for the read.
                  st.addr_rw[0] = 1'b1;
                  st.off_left = 2'd0;
                  r.bus_action = ACT_RSTART;
                end
              end else if (st.idx < st.limit && st.idx < BUF_DEPTH) begin
                r.bus_action = ACT_SEND;
                r.tx_byte = store_byte;
                if (st.idx != IDX_MAX) st.idx = st.idx + 6'd1;
              end else begin
                r.bus_action = ACT_STOP;
                st.err = ERR_NONE;
                st.mode = MODE_READY;
              end
            end
            BS_MT_ADDR_NACK, BS_MR_ADDR_NACK: begin
              r.bus_action = ACT_STOP;
              st.err = ERR_ADDR;
              st.mode = MODE_READY;
            end
            BS_MT_DATA_NACK: begin
              r.bus_action = ACT_STOP;
              st.err = ERR_DATA;
              st.mode = MODE_READY;
            end
            BS_ARB_LOST: begin
              r.bus_action = ACT_RELEASE;
              st.err = ERR_OTHER;
              st.mode = MODE_READY;
            end
            BS_MR_DATA_ACK, BS_MR_ADDR_ACK: begin
              if (code == BS_MR_DATA_ACK) begin
                r.rx_valid = 1'b1;
                r.rx_byte = it.data_byte;
                if (st.idx != IDX_MAX) st.idx = st.idx + 6'd1;
              end
              // Ack while another byte is still wanted after the next one.
              r.bus_action = ({1'b0, st.idx} + 7'd1 < {1'b0, st.limit}) ? ACT_ACK : ACT_NACK;
            end
            BS_MR_DATA_NACK: begin
              r.rx_valid = 1'b1;
              r.rx_byte = it.data_byte;
              if (st.idx != IDX_MAX) st.idx = st.idx + 6'd1;
              r.bus_action = ACT_STOP;
              st.err = ERR_NONE;
              st.mode = MODE_READY;
            end
            BS_BUS_ERROR: begin
              r.bus_action = ACT_STOP;
              st.err = ERR_OTHER;
              st.mode = MODE_READY;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (!status_set) begin
      if (st.mode != MODE_READY) begin
        r.result_status = ST_BUSY;
      end else begin
        case (st.err)
          ERR_NONE: r.result_status = ST_OK;
          ERR_ADDR: r.result_status = ST_ADDR_NACK;
          ERR_DATA: r.result_status = ST_DATA_NACK;
          default: r.result_status = ST_OTHER;
        endcase
      end
    end
    r.rx_count = st.idx;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic in_item_t item_of(input logic [1:0] op);
    logic [63:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.opcode = op;
    return it;
  endfunction

  task automatic plan_item(input in_item_t it);
    out_item_t r;
    logic      load_ok;
    r = sequence_step(plan_st, it, 8'h00, load_ok);
    if (load_ok) slot_loaded[it.buf_slot] = 1'b1;
    if (r.bus_action != ACT_NONE) begin
      last_act = r.bus_action;
      if (it.opcode == OP_EVENT)
        addr_phase = ({it.bus_status[7:3], 3'b000} == BS_START) ||
                     ({it.bus_status[7:3], 3'b000} == BS_RSTART);
    end
    if (it.opcode == OP_BEGIN || load_ok || r.bus_action != ACT_NONE) live_items++;
    tx_items.push_back(it);
    tx_hold.push_back(hold_next);
    hold_next = 1'b0;
  endtask

  // Every begin goes through here: store slots that the transaction may send are
  // loaded first, so no unwritten entry is ever put on the bus.
  task automatic offer(input in_item_t it);
    in_item_t ld;
    if (it.opcode == OP_BEGIN && it.xfer_length <= BUF_DEPTH && plan_st.mode == MODE_READY) begin
      for (int s = 0; s < it.xfer_length; s++) begin
        if (!slot_loaded[s]) begin
          ld = item_of(OP_LOAD);
          ld.buf_slot = 5'(s);
          plan_item(ld);
        end
      end
    end
    plan_item(it);
  endtask

  task automatic bus_event(input logic [7:0] code, input logic [7:0] data);
    in_item_t it;
    it = item_of(OP_EVENT);
    it.bus_status = {code[7:3], 3'($urandom_range(0, 7))};
    it.data_byte = data;
    offer(it);
  endtask

  task automatic start_txn(input logic [1:0] kind, input logic [6:0] addr,
                           input logic [15:0] offs, input logic [5:0] len);
    in_item_t it;
    it = item_of(OP_BEGIN);
    it.kind = kind;
    it.device_address = addr;
    it.reg_offset = offs;
    it.xfer_length = len;
    offer(it);
  endtask

  // Plays the bus engine until the transaction ends, answering each action the way a
  // well-behaved slave would, with occasional faults and stray items mixed in.
  task automatic drive_bus(input int fault_pct);
    logic [7:0] code;
    in_item_t   it;
    int         steps;
    steps = 0;
    while (plan_st.mode != MODE_READY && steps < 300) begin
      steps++;
      case (last_act)
        ACT_RSTART: code = BS_RSTART;
        ACT_SEND: begin
          if (!addr_phase) code = BS_MT_DATA_ACK;
          else if (plan_st.addr_rw[0]) code = BS_MR_ADDR_ACK;
          else code = BS_MT_ADDR_ACK;
        end
        ACT_ACK: code = BS_MR_DATA_ACK;
        ACT_NACK: code = BS_MR_DATA_NACK;
        default: code = BS_START;
      endcase
      if ($urandom_range(0, 99) < fault_pct) begin
        case ($urandom_range(0, 7))
          0: begin
            if (!addr_phase) code = BS_MT_DATA_NACK;
            else if (plan_st.addr_rw[0]) code = BS_MR_ADDR_NACK;
            else code = BS_MT_ADDR_NACK;
          end
          1: code = BS_ARB_LOST;
          2: code = BS_BUS_ERROR;
          3: code = {5'($urandom_range(12, 31)), 3'b000};
          4: code = BS_MT_ADDR_ACK;
          5: code = BS_MR_ADDR_ACK;
          6: offer(item_of(OP_BEGIN));
          default: begin
            it = item_of($urandom_range(0, 1) ? OP_LOAD : OP_UNDEF);
            offer(it);
          end
        endcase
      end
      bus_event(code, 8'($urandom));
    end
  endtask

  task automatic run_txn();
    logic [5:0] len;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) len = 6'd0;
    else if (pick < 85) len = 6'($urandom_range(1, 6));
    else if (pick < 95) len = 6'($urandom_range(7, 31));
    else len = 6'd32;
    start_txn(2'($urandom_range(0, 3)), 7'($urandom), 16'($urandom), len);
    drive_bus(4);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: offers planned items, predicts each one as its transfer completes.
  always @(posedge clk) begin : driver
    out_item_t want;
    logic      load_ok;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        want = sequence_step(chk_st, in_data, chk_store[chk_st.idx[4:0]], load_ok);
        if (load_ok) chk_store[in_data.buf_slot] = in_data.data_byte;
        predicted_results.push_back(want);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_items.size() != 0 &&
                     !(tx_hold[0] && predicted_results.size() != 0)) begin
          in_data <= tx_items.pop_front();
          tx_hold.delete(0);
          in_valid <= 1'b1;
          gap_left = tx_quiet ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) tx_quiet = !tx_quiet;
    end
  end

  // Monitor: takes results under random back-pressure and checks them in order.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        // Two long hold-offs so the input side backs up and stalls.
        if (results_seen == 400 || results_seen == 1100) hold_left = 200;
        if (predicted_results.size() == 0) begin
          $error("result transfer with none outstanding: %h", out_data);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("bus_action", 8'(want.bus_action), 8'(out_data.bus_action));
          check_field("tx_byte", want.tx_byte, out_data.tx_byte);
          check_field("rx_valid", 8'(want.rx_valid), 8'(out_data.rx_valid));
          check_field("rx_byte", want.rx_byte, out_data.rx_byte);
          check_field("rx_count", 8'(want.rx_count), 8'(out_data.rx_count));
          check_field("result_status", 8'(want.result_status), 8'(out_data.result_status));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = rx_quiet ? 0 : idle_len();
      end
      if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
    end
  end

  initial begin : stimulus
    in_item_t it;
    int       next_pause;
    for (int s = 0; s < BUF_DEPTH; s++) begin
      slot_loaded[s] = 1'b0;
      chk_store[s] = 8'h00;
    end

    // Store extremes, items with nothing to act on, and rejected arguments.
    it = item_of(OP_LOAD);
    it.buf_slot = 5'd0;
    it.data_byte = 8'h00;
    offer(it);
    it = item_of(OP_LOAD);
    it.buf_slot = 5'd31;
    it.data_byte = 8'hFF;
    offer(it);
    bus_event(BS_MT_DATA_ACK, 8'h5A);
    offer(item_of(OP_UNDEF));
    start_txn(KIND_READ, 7'h00, 16'h0000, 6'd0);
    start_txn(KIND_WRITE, 7'h7F, 16'hFFFF, 6'd33);

    // Write that ends on a data nack, with busy items and a no-info code inside.
    start_txn(KIND_WRITE, 7'h7F, 16'h0000, 6'd2);
    bus_event(BS_START, 8'h00);
    bus_event(BS_MT_ADDR_ACK, 8'h00);
    start_txn(KIND_READ, 7'h11, 16'h1234, 6'd1);
    offer(item_of(OP_LOAD));
    bus_event(8'hF8, 8'h00);
    bus_event(BS_MT_DATA_ACK, 8'h00);
    bus_event(BS_MT_DATA_NACK, 8'h00);

    // 16-bit offset read; a second address ack after the offset resends the low byte.
    start_txn(KIND_READ16, 7'h2A, 16'hFF00, 6'd2);
    bus_event(BS_START, 8'h00);
    bus_event(BS_MT_ADDR_ACK, 8'h00);
    bus_event(BS_MT_DATA_ACK, 8'h00);
    bus_event(BS_MT_ADDR_ACK, 8'h00);
    bus_event(BS_MT_DATA_ACK, 8'h00);
    bus_event(BS_RSTART, 8'h00);
    bus_event(BS_MR_ADDR_ACK, 8'h00);
    bus_event(BS_MR_DATA_ACK, 8'hFF);
    bus_event(BS_MR_DATA_NACK, 8'h00);

    // Read refused at the address.
    start_txn(KIND_READ, 7'h55, 16'h0000, 6'd1);
    bus_event(BS_START, 8'h00);
    bus_event(BS_MR_ADDR_NACK, 8'h00);

    // A slave that keeps sending past the end drives the byte count into saturation.
    start_txn(KIND_READ, 7'($urandom), 16'($urandom), 6'd2);
    bus_event(BS_START, 8'($urandom));
    bus_event(BS_MR_ADDR_ACK, 8'($urandom));
    repeat (70) bus_event(BS_MR_DATA_ACK, 8'($urandom));
    bus_event(BS_MR_DATA_NACK, 8'($urandom));

    next_pause = 500;
    while (live_items < 1500) begin
      if (live_items >= next_pause) begin
        hold_next = 1'b1;
        next_pause += 600;
      end
      if ($urandom_range(0, 99) < 85) begin
        run_txn();
      end else begin
        repeat ($urandom_range(1, 4)) offer(item_of(2'($urandom)));
        if (plan_st.mode != MODE_READY) drive_bus(4);
      end
    end
    tx_total = tx_items.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_items != tx_total) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("i2c_master_transaction_sequencer regression: pass");
    end else begin
      $display("i2c_master_transaction_sequencer regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("i2c_master_transaction_sequencer regression: fail");
    $finish;
  end

endmodule
